### design/tbpf_pkg.sv
// Shared types, constants and helpers for the background tile pixel fetch block.
package tbpf_pkg;

  localparam int unsigned VMEM_DEPTH = 8192;
  localparam int unsigned VMEM_AW    = 13;
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned CFG_DW     = 32;

  localparam logic [VMEM_AW-1:0] MAP_LOW_BASE  = 13'h1800;
  localparam logic [VMEM_AW-1:0] MAP_HIGH_BASE = 13'h1C00;

  localparam int unsigned CTRL_UNSIGNED_BIT = 4;
  localparam int unsigned CTRL_HIGH_MAP_BIT = 3;

  localparam logic [7:0] PAN_X_RST       = 8'd0;
  localparam logic [7:0] PAN_Y_RST       = 8'd0;
  localparam logic [7:0] LCD_CONTROL_RST = 8'd145;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_PAN_X       = 2'd0,
    REG_PAN_Y       = 2'd1,
    REG_LCD_CONTROL = 2'd2
  } reg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_PIXEL = 1'b1
  } req_kind_t;

  // One queued job: a memory write, or a pixel with its map address
  typedef struct packed {
    req_kind_t          kind;
    logic [VMEM_AW-1:0] addr;   // write address or tile map address
    logic [7:0]         data;   // write byte, or {2'b0, bx[2:0], by[2:0]}
  } job_t;

  // Status of the job queue as seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MAP  = 2'd1,
    ST_ROW  = 2'd2
  } back_st_t;

  function automatic logic [31:0] gray_shade(input logic [1:0] idx);
    logic [31:0] shade;
    case (idx)
      2'd0:    shade = 32'hFFFFFFFF;
      2'd1:    shade = 32'hAAAAAAAA;
      2'd2:    shade = 32'h66666666;
      default: shade = 32'h11111111;
    endcase
    return shade;
  endfunction

endpackage

### design/tbpf_in_if.sv
// Request channel: video memory writes and pixel requests.
interface tbpf_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [12:0] mem_address;
  logic [7:0] write_data;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (output valid, req_type, mem_address, write_data, pixel_x, pixel_y,
                  input ready);
  modport sink   (input valid, req_type, mem_address, write_data, pixel_x, pixel_y,
                  output ready);
endinterface

### design/tbpf_out_if.sv
// Result channel: color index and gray RGBA value of one pixel.
interface tbpf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  color_index;
  logic [31:0] rgba_color;

  modport source (output valid, color_index, rgba_color, input ready);
  modport sink   (input valid, color_index, rgba_color, output ready);
endinterface

### design/tbpf_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module tbpf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re_a,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic              re_b,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read ports, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

### design/tbpf_front.sv
// Front end: accept requests, drop off-screen pixels, form the tile map address.
module tbpf_front #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  tbpf_in_if.sink           in_req,
  input  logic [7:0]        pan_x,
  input  logic [7:0]        pan_y,
  input  logic [7:0]        lcd_control,
  input  tbpf_pkg::q_stat_t q_stat,
  output logic              push,
  output tbpf_pkg::job_t    push_job
);

  logic       on_screen;
  logic [7:0] bx;
  logic [7:0] by;
  logic [tbpf_pkg::VMEM_AW-1:0] map_base;

  assign in_req.ready = !q_stat.full;

  // Screen bounds and background coordinate, wrapping modulo 256
  assign on_screen = ({1'b0, in_req.pixel_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, in_req.pixel_y} < 9'(SCREEN_HEIGHT));
  assign bx = in_req.pixel_x + pan_x;
  assign by = in_req.pixel_y + pan_y;

  assign map_base = lcd_control[tbpf_pkg::CTRL_HIGH_MAP_BIT] ?
                    tbpf_pkg::MAP_HIGH_BASE : tbpf_pkg::MAP_LOW_BASE;

  // Classify and build the queued job
  always_comb begin
    push_job = '0;
    if (in_req.req_type == tbpf_pkg::REQ_WRITE) begin
      push_job.kind = tbpf_pkg::REQ_WRITE;
      push_job.addr = in_req.mem_address;
      push_job.data = in_req.write_data;
      push = in_req.valid && !q_stat.full;
    end else begin
      push_job.kind = tbpf_pkg::REQ_PIXEL;
      push_job.addr = map_base + {3'b000, by[7:3], bx[7:3]};
      push_job.data = {2'b00, bx[2:0], by[2:0]};
      push = in_req.valid && !q_stat.full && on_screen;
    end
  end

endmodule

### design/tbpf_queue.sv
// Two-entry job queue between front and back end.
module tbpf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tbpf_pkg::job_t    push_job,
  input  logic              pop,
  output tbpf_pkg::job_t    head,
  output tbpf_pkg::q_stat_t q_stat
);

  tbpf_pkg::job_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/tbpf_back.sv
// Back end: run writes and pixel fetches against video memory, hold the result.
module tbpf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        lcd_control,
  input  tbpf_pkg::job_t    head,
  input  tbpf_pkg::q_stat_t q_stat,
  output logic              pop,
  tbpf_out_if.source        out_res
);

  tbpf_pkg::back_st_t st_r, st_nxt;

  logic [5:0]  lane_r, lane_nxt;        // {bx[2:0], by[2:0]} of the pixel in flight
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  color_index_r, color_index_nxt;
  logic [31:0] rgba_color_r, rgba_color_nxt;

  logic        out_free;
  logic        can_start;
  logic        start_pixel;
  logic        load_out;
  logic        we;
  logic        re_a;
  logic        re_b;
  logic [tbpf_pkg::VMEM_AW-1:0] raddr_a;
  logic [tbpf_pkg::VMEM_AW-1:0] row_lo;
  logic [tbpf_pkg::VMEM_AW-1:0] row_hi;
  logic [7:0]  rdata_a;
  logic [7:0]  rdata_b;
  logic        tile_bit12;
  logic [2:0]  bit_sel;
  logic [1:0]  pix_idx;

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (tbpf_pkg::VMEM_DEPTH)
  ) u_vmem (
    .clk     (clk),
    .we      (we),
    .waddr   (head.addr),
    .wdata   (head.data),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (row_hi),
    .rdata_b (rdata_b)
  );

  // Row address from tile number: signed numbers sit around the upper area
  assign tile_bit12 = lcd_control[tbpf_pkg::CTRL_UNSIGNED_BIT] ? 1'b0 : !rdata_a[7];
  assign row_lo = {tile_bit12, rdata_a, lane_r[2:0], 1'b0};
  assign row_hi = {tile_bit12, rdata_a, lane_r[2:0], 1'b1};

  // Leftmost pixel is bit 7
  assign bit_sel = ~lane_r[5:3];
  assign pix_idx = {rdata_b[bit_sel], rdata_a[bit_sel]};

  assign out_free    = !out_valid_r || out_res.ready;
  assign can_start   = (st_r == tbpf_pkg::ST_IDLE) || ((st_r == tbpf_pkg::ST_ROW) && out_free);
  assign pop         = can_start && !q_stat.empty;
  assign start_pixel = pop && (head.kind == tbpf_pkg::REQ_PIXEL);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tbpf_pkg::ST_IDLE: begin
        if (start_pixel) begin
          st_nxt = tbpf_pkg::ST_MAP;
        end
      end
      tbpf_pkg::ST_MAP: begin
        st_nxt = tbpf_pkg::ST_ROW;
      end
      tbpf_pkg::ST_ROW: begin
        if (out_free) begin
          st_nxt = start_pixel ? tbpf_pkg::ST_MAP : tbpf_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = tbpf_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory controls and result load
  always_comb begin
    we       = 1'b0;
    re_a     = 1'b0;
    re_b     = 1'b0;
    raddr_a  = head.addr;
    load_out = 1'b0;
    case (st_r)
      tbpf_pkg::ST_IDLE: begin
        we   = pop && (head.kind == tbpf_pkg::REQ_WRITE);
        re_a = start_pixel;
      end
      tbpf_pkg::ST_MAP: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = row_lo;
      end
      tbpf_pkg::ST_ROW: begin
        load_out = out_free;
        we       = pop && (head.kind == tbpf_pkg::REQ_WRITE);
        re_a     = start_pixel;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Hold result until taken
  always_comb begin
    lane_nxt        = start_pixel ? head.data[5:0] : lane_r;
    out_valid_nxt   = out_valid_r;
    color_index_nxt = color_index_r;
    rgba_color_nxt  = rgba_color_r;
    if (load_out) begin
      out_valid_nxt   = 1'b1;
      color_index_nxt = pix_idx;
      rgba_color_nxt  = tbpf_pkg::gray_shade(pix_idx);
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tbpf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r        <= lane_nxt;
    color_index_r <= color_index_nxt;
    rgba_color_r  <= rgba_color_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.color_index = color_index_r;
  assign out_res.rgba_color  = rgba_color_r;

endmodule

### design/tile_background_pixel_fetch.sv
// Top level of the background tile pixel fetch block.
//
// Holds an 8 KiB video memory and renders background pixels on request.
// in_req carries one transaction per item: req_type 0 writes write_data at
// mem_address, req_type 1 asks for the pixel at (pixel_x, pixel_y). Pixels
// outside the screen are dropped without a result. out_res returns one
// color_index and gray rgba_color per on-screen pixel, in request order.
// The APB-style port holds the horizontal pan (0x0), the vertical pan (0x4)
// and lcd_control (0x8); write them only while no transaction is in flight.
// A pixel goes from the job queue through the map read, then the two
// bit-plane reads on the two video memory read ports once the map read
// returns, then the result register; a new pixel's map read can start
// as a result loads. Writes go one per cycle while no fetch holds the queue.
// A two-entry job queue sits between the front end and the memory
// sequencer; the result waits in an output register, so the queue keeps
// filling while out_res is stalled and in_req.ready drops once it is full.
// Reset clears the queue, the result register and the config registers
// (lcd_control to 0x91); memory contents are undefined until written.
module tile_background_pixel_fetch #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tbpf_in_if.sink                     in_req,
  tbpf_out_if.source                  out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbpf_pkg::CFG_AW-1:0] paddr,
  input  logic [tbpf_pkg::CFG_DW-1:0] pwdata,
  output logic [tbpf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  logic [7:0] pan_x_r, pan_x_nxt;
  logic [7:0] pan_y_r, pan_y_nxt;
  logic [7:0] lcd_control_r, lcd_control_nxt;
  logic       cfg_wr;

  logic              q_push;
  logic              q_pop;
  tbpf_pkg::job_t    q_in;
  tbpf_pkg::job_t    q_head;
  tbpf_pkg::q_stat_t q_stat;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    pan_x_nxt       = pan_x_r;
    pan_y_nxt       = pan_y_r;
    lcd_control_nxt = lcd_control_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        tbpf_pkg::REG_PAN_X:       pan_x_nxt       = pwdata[7:0];
        tbpf_pkg::REG_PAN_Y:       pan_y_nxt       = pwdata[7:0];
        tbpf_pkg::REG_LCD_CONTROL: lcd_control_nxt = pwdata[7:0];
        default:                   pan_x_nxt       = pan_x_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tbpf_pkg::REG_PAN_X:       prdata = {24'd0, pan_x_r};
      tbpf_pkg::REG_PAN_Y:       prdata = {24'd0, pan_y_r};
      tbpf_pkg::REG_LCD_CONTROL: prdata = {24'd0, lcd_control_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_x_r       <= tbpf_pkg::PAN_X_RST;
      pan_y_r       <= tbpf_pkg::PAN_Y_RST;
      lcd_control_r <= tbpf_pkg::LCD_CONTROL_RST;
    end else begin
      pan_x_r       <= pan_x_nxt;
      pan_y_r       <= pan_y_nxt;
      lcd_control_r <= lcd_control_nxt;
    end
  end

  tbpf_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_req      (in_req),
    .pan_x       (pan_x_r),
    .pan_y       (pan_y_r),
    .lcd_control (lcd_control_r),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_job    (q_in)
  );

  tbpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .q_stat   (q_stat)
  );

  tbpf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .lcd_control (lcd_control_r),
    .head        (q_head),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .out_res     (out_res)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  a_out_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_res.valid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |=>
      (out_res.valid && $stable(out_res.color_index) && $stable(out_res.rgba_color)))
    else $error("stalled result changed");
`endif

endmodule

### test/tbpf_checker.sv
// Checker for the background pixel fetch block: predicts every pixel and compares results.
module tbpf_checker #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tbpf_in_if                          in_req,
  tbpf_out_if                         out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tbpf_pkg::CFG_AW-1:0] paddr,
  input  logic [tbpf_pkg::CFG_DW-1:0] pwdata,
  output int                          fail_count,
  output int                          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  color_index;
    logic [31:0] rgba_color;
  } pixel_t;

  // Mirror of the video memory and the registers
  logic [7:0] vram_model [tbpf_pkg::VMEM_DEPTH];
  logic [7:0] pan_x_q;
  logic [7:0] pan_y_q;
  logic [7:0] lcd_control_q;

  // Pixels accepted but not yet returned, oldest first
  pixel_t pixel_results_q [$];

  // Walk the map and tile row for one screen pixel
  function automatic pixel_t render_pixel(logic [7:0] px, logic [7:0] py);
    logic [7:0]  bx;
    logic [7:0]  by;
    logic [7:0]  tile_no;
    logic [12:0] map_a;
    logic [12:0] tile_a;
    logic [12:0] row_a;
    logic [7:0]  lo_plane;
    logic [7:0]  hi_plane;
    logic [2:0]  bit_pos;
    pixel_t      res;
    bx = px + pan_x_q;
    by = py + pan_y_q;
    map_a = (lcd_control_q[tbpf_pkg::CTRL_HIGH_MAP_BIT] ?
             tbpf_pkg::MAP_HIGH_BASE : tbpf_pkg::MAP_LOW_BASE)
            + {by[7:3], bx[7:3]};
    tile_no = vram_model[map_a];
    // signed numbers sit around 0x1000 and wrap down for negative tiles
    if (lcd_control_q[tbpf_pkg::CTRL_UNSIGNED_BIT]) begin
      tile_a = {1'b0, tile_no, 4'b0000};
    end else begin
      tile_a = 13'h1000 + {tile_no[7], tile_no, 4'b0000};
    end
    row_a    = tile_a + {by[2:0], 1'b0};
    lo_plane = vram_model[row_a];
    hi_plane = vram_model[row_a + 13'd1];
    bit_pos  = 3'd7 - bx[2:0];
    res.color_index = {hi_plane[bit_pos], lo_plane[bit_pos]};
    case (res.color_index)
      2'd0:    res.rgba_color = 32'hFFFFFFFF;
      2'd1:    res.rgba_color = 32'hAAAAAAAA;
      2'd2:    res.rgba_color = 32'h66666666;
      default: res.rgba_color = 32'h11111111;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      pan_x_q       = tbpf_pkg::PAN_X_RST;
      pan_y_q       = tbpf_pkg::PAN_Y_RST;
      lcd_control_q = tbpf_pkg::LCD_CONTROL_RST;
      pixel_results_q.delete();
      fail_count      = 0;
      pending_results = 0;
    end else begin
      // Compare a result transaction with the oldest prediction
      if (out_res.valid && out_res.ready) begin
        got.color_index = out_res.color_index;
        got.rgba_color  = out_res.rgba_color;
        if (pixel_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t ERROR: result with none expected: index %0d rgba %h",
                     $realtime, got.color_index, got.rgba_color);
        end else begin
          want = pixel_results_q.pop_front();
          if (got.color_index !== want.color_index || got.rgba_color !== want.rgba_color) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t ERROR: pixel mismatch: index exp %0d got %0d, rgba exp %h got %h",
                       $realtime, want.color_index, got.color_index,
                       want.rgba_color, got.rgba_color);
          end
        end
      end

      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (tbpf_pkg::reg_idx_t'(paddr[3:2]))
          tbpf_pkg::REG_PAN_X:       pan_x_q       = pwdata[7:0];
          tbpf_pkg::REG_PAN_Y:       pan_y_q       = pwdata[7:0];
          tbpf_pkg::REG_LCD_CONTROL: lcd_control_q = pwdata[7:0];
          default: ;
        endcase
      end

      // Apply a request transaction; drop off-screen pixels
      if (in_req.valid && in_req.ready) begin
        if (in_req.req_type == tbpf_pkg::REQ_WRITE) begin
          vram_model[in_req.mem_address] = in_req.write_data;
        end else if (in_req.pixel_x < SCREEN_WIDTH && in_req.pixel_y < SCREEN_HEIGHT) begin
          pixel_results_q.push_back(render_pixel(in_req.pixel_x, in_req.pixel_y));
        end
      end
      pending_results = pixel_results_q.size();
    end
  end

endmodule

### test/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the background pixel fetch block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCREEN_W = 160;
  localparam int unsigned SCREEN_H = 144;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 210;
  localparam int DRAIN_CYCLES = 16;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic                        pready;
  logic [tbpf_pkg::CFG_AW-1:0] paddr;
  logic [tbpf_pkg::CFG_DW-1:0] pwdata;
  logic [tbpf_pkg::CFG_DW-1:0] prdata;

  int fail_count;
  int pending_results;
  int tx_idle_pct;
  int rx_idle_pct;
  int items_sent;

  // What the stimulus has written so far, used to steer pixel requests
  logic [7:0] vram_shadow [tbpf_pkg::VMEM_DEPTH];
  bit         vram_known  [tbpf_pkg::VMEM_DEPTH];
  logic [7:0] cur_pan_x;
  logic [7:0] cur_pan_y;
  logic [7:0] cur_lcd_control;

  tbpf_in_if  in_req ();
  tbpf_out_if out_res ();

  tile_background_pixel_fetch #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tbpf_checker #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req          (in_req),
    .out_res         (out_res),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Map byte address touched by a screen pixel under the current settings
  function automatic logic [12:0] map_addr_of(logic [7:0] px, logic [7:0] py);
    logic [7:0] bx;
    logic [7:0] by;
    bx = px + cur_pan_x;
    by = py + cur_pan_y;
    return (cur_lcd_control[tbpf_pkg::CTRL_HIGH_MAP_BIT] ?
            tbpf_pkg::MAP_HIGH_BASE : tbpf_pkg::MAP_LOW_BASE)
           + {by[7:3], bx[7:3]};
  endfunction

  // Low plane address of the tile row that a pixel lands in
  function automatic logic [12:0] row_addr_of(logic [7:0] tile_no, logic [7:0] py);
    logic [7:0]  by;
    logic [12:0] base;
    by = py + cur_pan_y;
    if (cur_lcd_control[tbpf_pkg::CTRL_UNSIGNED_BIT]) begin
      base = {1'b0, tile_no, 4'b0000};
    end else begin
      base = 13'h1000 + {tile_no[7], tile_no, 4'b0000};
    end
    return base + {by[2:0], 1'b0};
  endfunction

  // Drive one request transaction and hold it until accepted
  task automatic send_item(tbpf_pkg::req_kind_t kind, logic [12:0] addr, logic [7:0] data,
                           logic [7:0] px, logic [7:0] py);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.req_type    <= kind;
    in_req.mem_address <= addr;
    in_req.write_data  <= data;
    in_req.pixel_x     <= px;
    in_req.pixel_y     <= py;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_write(logic [12:0] addr, logic [7:0] data);
    vram_shadow[addr] = data;
    vram_known[addr]  = 1'b1;
    send_item(tbpf_pkg::REQ_WRITE, addr, data, 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  // Fill any unwritten map or row byte first, then ask for the pixel
  task automatic request_pixel(logic [7:0] px, logic [7:0] py);
    logic [12:0] map_a;
    logic [12:0] row_a;
    if (px < SCREEN_W && py < SCREEN_H) begin
      map_a = map_addr_of(px, py);
      if (!vram_known[map_a]) send_write(map_a, 8'($urandom_range(255)));
      row_a = row_addr_of(vram_shadow[map_a], py);
      if (!vram_known[row_a]) send_write(row_a, 8'($urandom_range(255)));
      if (!vram_known[row_a + 13'd1]) send_write(row_a + 13'd1, 8'($urandom_range(255)));
    end
    send_item(tbpf_pkg::REQ_PIXEL, 13'($urandom_range(tbpf_pkg::VMEM_DEPTH - 1)),
              8'($urandom_range(255)), px, py);
  endtask

  // Hold off requests until every pixel has come back and the pipe is empty
  task automatic drain_results();
    in_req.valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Setup and access cycle of one register write
  task automatic cfg_write(tbpf_pkg::reg_idx_t idx, logic [7:0] value);
    case (idx)
      tbpf_pkg::REG_PAN_X:       cur_pan_x       = value;
      tbpf_pkg::REG_PAN_Y:       cur_pan_y       = value;
      tbpf_pkg::REG_LCD_CONTROL: cur_lcd_control = value;
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int          phase_end;
    int          pick;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  lcd;
    in_req.valid       = 1'b0;
    in_req.req_type    = tbpf_pkg::REQ_WRITE;
    in_req.mem_address = '0;
    in_req.write_data  = '0;
    in_req.pixel_x     = '0;
    in_req.pixel_y     = '0;
    out_res.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rst_n              = 1'b0;
    tx_idle_pct        = 15;
    rx_idle_pct        = 49;
    items_sent         = 0;
    cur_pan_x          = tbpf_pkg::PAN_X_RST;
    cur_pan_y          = tbpf_pkg::PAN_Y_RST;
    cur_lcd_control    = tbpf_pkg::LCD_CONTROL_RST;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: address and data extremes, screen corners, off-screen pixels
    send_write(13'h0000, 8'h00);
    send_write(13'h1FFF, 8'hFF);
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd159, 8'd143);
    request_pixel(8'd160, 8'd0);
    request_pixel(8'd0, 8'd144);
    request_pixel(8'd255, 8'd255);

    // Directed: signed tiles from the high map, pan wrapping past 255
    drain_results();
    cfg_write(tbpf_pkg::REG_LCD_CONTROL, 8'h08);
    cfg_write(tbpf_pkg::REG_PAN_X, 8'hFF);
    cfg_write(tbpf_pkg::REG_PAN_Y, 8'hFF);
    send_write(map_addr_of(8'd0, 8'd0), 8'h80);
    request_pixel(8'd0, 8'd0);
    send_write(map_addr_of(8'd1, 8'd1), 8'h7F);
    request_pixel(8'd1, 8'd1);

    // Random phases, each with its own settings, in three idle mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p < 3) begin
        tx_idle_pct = 15;
        rx_idle_pct = 49;
      end else if (p < 6) begin
        tx_idle_pct = 49;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: begin
          sx  = 8'h00;
          sy  = 8'h00;
          lcd = 8'hFF;
        end
        1: begin
          sx  = 8'hFF;
          sy  = 8'hFF;
          lcd = 8'h00;
        end
        default: begin
          sx  = 8'($urandom_range(255));
          sy  = 8'($urandom_range(255));
          lcd = 8'($urandom_range(255));
        end
      endcase
      cfg_write(tbpf_pkg::REG_PAN_X, sx);
      cfg_write(tbpf_pkg::REG_PAN_Y, sy);
      cfg_write(tbpf_pkg::REG_LCD_CONTROL, lcd);

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          request_pixel(8'($urandom_range(SCREEN_W - 1)), 8'($urandom_range(SCREEN_H - 1)));
        end else if (pick < 65) begin
          // off screen in one axis or the other
          if ($urandom_range(1))
            request_pixel(8'($urandom_range(255, SCREEN_W)), 8'($urandom_range(255)));
          else
            request_pixel(8'($urandom_range(255)), 8'($urandom_range(255, SCREEN_H)));
        end else begin
          send_write(13'($urandom_range(tbpf_pkg::VMEM_DEPTH - 1)), 8'($urandom_range(255)));
        end
      end
    end

    drain_results();
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
